### sv/spi_pkg.sv
// Shared widths, codes and beat types for the segment/plane intersection unit.
// No dependencies; used by every module of the block.
package spi_pkg;

    localparam int CW       = 32;          // coordinate / coefficient width
    localparam int TW       = 16;          // tolerance width
    localparam int PW       = 64;          // one coefficient * coordinate product
    localparam int SW       = 66;          // signed plane distance
    localparam int MW       = 65;          // magnitude of distance and of distance difference
    localparam int DW       = 32;          // magnitude of end - start per axis
    localparam int LOW_W    = 33;          // low slice of the distance magnitude
    localparam int HIW      = MW - LOW_W;  // high slice
    localparam int PRW      = DW + MW;     // dividend width
    localparam int QW       = DW;          // quotient bits, one per divider stage
    localparam int AW       = 3;           // config address width
    localparam int FRAC_DEF = 16;
    localparam int QDEPTH   = 4;

    typedef enum logic [AW-1:0] {
        REG_NX  = 3'd0,
        REG_NY  = 3'd1,
        REG_NZ  = 3'd2,
        REG_OFS = 3'd3,
        REG_TOL = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_ENDPT = 2'd1,
        K_CROSS = 2'd2
    } t_kind;

    localparam logic [1:0] SIDE_NONE  = 2'b00;
    localparam logic [1:0] SIDE_ABOVE = 2'b01;
    localparam logic [1:0] SIDE_BELOW = 2'b11;

    typedef struct packed {
        logic [CW-1:0] nx;
        logic [CW-1:0] ny;
        logic [CW-1:0] nz;
        logic [CW-1:0] ofs;
        logic [TW-1:0] tol;
    } t_plane;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         side;
        logic [2:0][CW-1:0] start;
        logic [2:0][CW-1:0] endc;
        logic [2:0]         neg;
    } t_meta;

    typedef struct packed {
        t_meta              meta;
        logic [2:0][DW-1:0] dm;
        logic [MW-1:0]      smag;
        logic [MW-1:0]      dmag;
    } t_item;

endpackage

### sv/segment_plane_intersect_unit.sv
// Segment / plane intersection unit: top level with configuration registers.
// Depends on spi_pkg, spi_front, spi_queue and spi_back.
//
// Usage
//   Slave channel: one beat carries a segment, start x/y/z then end x/y/z, signed Q16.16.
//   Master channel: one beat per segment: hit point in tdata, side and endpoint flag in tuser.
//   Configuration: write the plane coefficients and tolerance through i_cfg_we/addr/data
//   while no beat is in flight; a write takes effect at the next clock edge.
// Throughput and pipeline
//   One beat per cycle unless the master side stalls. Stages: four in the front (products,
//   two adder levels, classification), one through the queue, one split multiply, one
//   divider load, 32 divider stages (one quotient bit each) and the output register.
// Reset
//   Synchronous, active low: empties all pipes and the queue, loads the plane z = 0
//   (c = 1.0) with a tolerance of 66 lsb.
// Stall
//   A master-side stall freezes the back pipe; the queue then fills and the front
//   drops s_axis_tready once its last stage cannot drain into the queue.
module segment_plane_intersect_unit #(
    parameter int COORD_FRAC_BITS = spi_pkg::FRAC_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each, lowest first)
    input  logic [6*spi_pkg::CW-1:0] s_axis_tdata,
    // master stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // hit_x, hit_y, hit_z (32 bits each, lowest first)
    output logic [3*spi_pkg::CW-1:0] m_axis_tdata,
    // side [1:0], at_endpoint [2]
    output logic [2:0]               m_axis_tuser,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [spi_pkg::AW-1:0]   i_cfg_addr,
    input  logic [spi_pkg::CW-1:0]   i_cfg_data
);
    localparam int CW = spi_pkg::CW;

    spi_pkg::t_plane    r_plane;
    spi_pkg::t_item     push_item, head_item;
    logic               push, pop, q_full, q_empty;
    logic [1:0]         side;
    logic [2:0][CW-1:0] hit;
    logic               at;
    logic [5:0][CW-1:0] coord;

    // hold the plane; unlisted addresses are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane.nx  <= '0;
            r_plane.ny  <= '0;
            r_plane.nz  <= CW'(1) << COORD_FRAC_BITS;
            r_plane.ofs <= '0;
            r_plane.tol <= spi_pkg::TW'(66);
        end else if (i_cfg_we) begin
            unique case (spi_pkg::t_reg'(i_cfg_addr))
                spi_pkg::REG_NX:  r_plane.nx  <= i_cfg_data;
                spi_pkg::REG_NY:  r_plane.ny  <= i_cfg_data;
                spi_pkg::REG_NZ:  r_plane.nz  <= i_cfg_data;
                spi_pkg::REG_OFS: r_plane.ofs <= i_cfg_data;
                spi_pkg::REG_TOL: r_plane.tol <= i_cfg_data[spi_pkg::TW-1:0];
                default: ;
            endcase
        end
    end

    assign coord = s_axis_tdata;

    spi_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (r_plane),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_coord (coord),
        .i_full  (q_full),
        .o_push  (push),
        .o_item  (push_item)
    );

    spi_queue #(
        .DEPTH(spi_pkg::QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (head_item)
    );

    spi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_item  (head_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_side  (side),
        .o_hit   (hit),
        .o_at    (at)
    );

    assign m_axis_tdata = hit;
    assign m_axis_tuser = {at, side};

endmodule

### sv/spi_front.sv
// Front part: plane distance of both endpoints, classification, operand magnitudes.
// Depends on spi_pkg.
module spi_front #(
    parameter int COORD_FRAC_BITS = spi_pkg::FRAC_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spi_pkg::t_plane                     i_plane,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [5:0][spi_pkg::CW-1:0]         i_coord,
    input  logic                                i_full,
    output logic                                o_push,
    output spi_pkg::t_item                      o_item
);
    localparam int CW = spi_pkg::CW;
    localparam int PW = spi_pkg::PW;
    localparam int SW = spi_pkg::SW;
    localparam int MW = spi_pkg::MW;
    localparam int DW = spi_pkg::DW;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [5:0][CW-1:0]   r_c1, r_c2, r_c3, r_c4;
    logic signed [PW-1:0] r_pa [6];
    logic signed [PW-1:0] r_dof;
    logic signed [SW-1:0] r_h [4];
    logic signed [SW-1:0] r_s1, r_s2;
    logic [1:0]           r_side1, r_side2;
    logic signed [SW-1:0] r_d1;
    logic signed [SW:0]   r_den;
    logic                 en;
    logic signed [SW-1:0] band;
    logic [1:0]           n_side1, n_side2;
    logic signed [CW-1:0] nrm [3];

    assign en      = !r_v4 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v4 && !i_full;
    assign band    = SW'($signed({1'b0, i_plane.tol})) <<< COORD_FRAC_BITS;
    assign nrm[0]  = $signed(i_plane.nx);
    assign nrm[1]  = $signed(i_plane.ny);
    assign nrm[2]  = $signed(i_plane.nz);

    always_comb begin
        if (r_s1 < -band) begin
            n_side1 = spi_pkg::SIDE_BELOW;
        end else if (r_s1 > band) begin
            n_side1 = spi_pkg::SIDE_ABOVE;
        end else begin
            n_side1 = spi_pkg::SIDE_NONE;
        end
        if (r_s2 < -band) begin
            n_side2 = spi_pkg::SIDE_BELOW;
        end else if (r_s2 > band) begin
            n_side2 = spi_pkg::SIDE_ABOVE;
        end else begin
            n_side2 = spi_pkg::SIDE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // products of both endpoints
            for (int k = 0; k < 3; k++) begin
                r_pa[k]     <= PW'(nrm[k]) * PW'($signed(i_coord[k]));
                r_pa[k + 3] <= PW'(nrm[k]) * PW'($signed(i_coord[k + 3]));
            end
            r_dof <= PW'($signed(i_plane.ofs)) <<< COORD_FRAC_BITS;
            r_c1  <= i_coord;
            // partial sums
            r_h[0] <= SW'(r_dof) + SW'(r_pa[0]);
            r_h[1] <= SW'(r_pa[1]) + SW'(r_pa[2]);
            r_h[2] <= SW'(r_dof) + SW'(r_pa[3]);
            r_h[3] <= SW'(r_pa[4]) + SW'(r_pa[5]);
            r_c2   <= r_c1;
            // distances
            r_s1 <= r_h[0] + r_h[1];
            r_s2 <= r_h[2] + r_h[3];
            r_c3 <= r_c2;
            // classify
            r_side1 <= n_side1;
            r_side2 <= n_side2;
            r_d1    <= r_s1;
            r_den   <= (SW + 1)'(r_s2) - (SW + 1)'(r_s1);
            r_c4    <= r_c3;
        end
    end

    always_comb begin
        logic signed [DW:0] dv;
        o_item = '0;
        o_item.meta.side = r_side1;
        if (r_side1 == spi_pkg::SIDE_NONE) begin
            o_item.meta.kind = spi_pkg::K_NONE;
        end else if (r_side2 == spi_pkg::SIDE_NONE) begin
            o_item.meta.kind = spi_pkg::K_ENDPT;
        end else if (r_side1 == r_side2) begin
            o_item.meta.kind = spi_pkg::K_NONE;
        end else begin
            o_item.meta.kind = spi_pkg::K_CROSS;
        end
        for (int k = 0; k < 3; k++) begin
            dv = (DW + 1)'($signed(r_c4[k + 3])) - (DW + 1)'($signed(r_c4[k]));
            o_item.meta.start[k] = r_c4[k];
            o_item.meta.endc[k]  = r_c4[k + 3];
            o_item.meta.neg[k]   = dv[DW];
            o_item.dm[k]         = dv[DW] ? DW'(-dv) : DW'(dv);
        end
        o_item.smag = r_d1[SW-1] ? MW'(-r_d1) : MW'(r_d1);
        o_item.dmag = r_den[SW] ? MW'(-r_den) : MW'(r_den);
    end

endmodule

### sv/spi_queue.sv
// Short queue between the classifying front and the dividing back.
// Depends on spi_pkg.
module spi_queue #(
    parameter int DEPTH = spi_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spi_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output spi_pkg::t_item o_data
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    spi_pkg::t_item  r_mem [DEPTH];
    logic [PTRW-1:0] r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            push_ok, pop_ok;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PTRW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PTRW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNTW'(push_ok) - CNTW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### sv/spi_back.sv
// Back part: split multiply, pipelined restoring divide, point assembly and output beat.
// Depends on spi_pkg.
module spi_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  spi_pkg::t_item               i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_side,
    output logic [2:0][spi_pkg::CW-1:0]  o_hit,
    output logic                         o_at
);
    localparam int CW    = spi_pkg::CW;
    localparam int MW    = spi_pkg::MW;
    localparam int DW    = spi_pkg::DW;
    localparam int QW    = spi_pkg::QW;
    localparam int LOW_W = spi_pkg::LOW_W;
    localparam int HIW   = spi_pkg::HIW;
    localparam int PRW   = spi_pkg::PRW;

    typedef struct packed {
        spi_pkg::t_meta              meta;
        logic [MW-1:0]               den;
        logic [2:0][DW+LOW_W-1:0]    pl;
        logic [2:0][DW+HIW-1:0]      ph;
    } t_mul;

    typedef struct packed {
        spi_pkg::t_meta              meta;
        logic [MW-1:0]               den;
        logic [2:0][MW-1:0]          rem;
        logic [2:0][DW-1:0]          low;
        logic [2:0][QW-1:0]          q;
    } t_div;

    logic   en;
    logic   r_mv;
    t_mul   r_m;
    logic   r_dv [QW+1];
    t_div   r_d  [QW+1];
    t_div   n_d  [QW+1];
    logic   r_ov;
    logic [1:0]          r_side;
    logic [2:0][CW-1:0]  r_hit;
    logic                r_at;
    logic [1:0]          n_side;
    logic [2:0][CW-1:0]  n_hit;
    logic                n_at;

    assign en      = !r_ov || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_side  = r_side;
    assign o_hit   = r_hit;
    assign o_at    = r_at;

    // load the divider from the two partial products, then one quotient bit per stage
    always_comb begin
        logic [PRW-1:0] p;
        logic [MW:0]    t;
        logic           ge;
        n_d[0].meta = r_m.meta;
        n_d[0].den  = r_m.den;
        for (int k = 0; k < 3; k++) begin
            p = PRW'(r_m.pl[k]) + (PRW'(r_m.ph[k]) << LOW_W);
            n_d[0].rem[k] = p[PRW-1:DW];
            n_d[0].low[k] = p[DW-1:0];
            n_d[0].q[k]   = '0;
        end
        for (int j = 0; j < QW; j++) begin
            n_d[j+1].meta = r_d[j].meta;
            n_d[j+1].den  = r_d[j].den;
            for (int k = 0; k < 3; k++) begin
                t  = {r_d[j].rem[k], r_d[j].low[k][DW-1]};
                ge = (t >= {1'b0, r_d[j].den});
                n_d[j+1].rem[k] = ge ? MW'(t - {1'b0, r_d[j].den}) : MW'(t);
                n_d[j+1].low[k] = r_d[j].low[k] << 1;
                n_d[j+1].q[k]   = {r_d[j].q[k][QW-2:0], ge};
            end
        end
    end

    // assemble the result beat from the last divider stage
    always_comb begin
        logic signed [CW+1:0] sum;
        t_div                 d;
        d      = r_d[QW];
        n_side = spi_pkg::SIDE_NONE;
        n_hit  = '0;
        n_at   = 1'b0;
        case (d.meta.kind)
            spi_pkg::K_ENDPT: begin
                n_side = d.meta.side;
                n_hit  = d.meta.endc;
                n_at   = 1'b1;
            end
            spi_pkg::K_CROSS: begin
                n_side = d.meta.side;
                for (int k = 0; k < 3; k++) begin
                    sum = d.meta.neg[k]
                        ? (CW + 2)'($signed(d.meta.start[k])) - (CW + 2)'(d.q[k])
                        : (CW + 2)'($signed(d.meta.start[k])) + (CW + 2)'(d.q[k]);
                    if (sum > (CW + 2)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
                        n_hit[k] = {1'b0, {(CW-1){1'b1}}};
                    end else if (sum < -(CW + 2)'(signed'({1'b0, 1'b1, {(CW-1){1'b0}}}))) begin
                        n_hit[k] = {1'b1, {(CW-1){1'b0}}};
                    end else begin
                        n_hit[k] = sum[CW-1:0];
                    end
                end
            end
            default: begin
                n_side = spi_pkg::SIDE_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
            for (int j = 0; j <= QW; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else if (en) begin
            r_mv    <= !i_empty;
            r_dv[0] <= r_mv;
            for (int j = 0; j < QW; j++) begin
                r_dv[j+1] <= r_dv[j];
            end
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m.meta <= i_item.meta;
            r_m.den  <= i_item.dmag;
            for (int k = 0; k < 3; k++) begin
                r_m.pl[k] <= (DW + LOW_W)'(i_item.dm[k]) * (DW + LOW_W)'(i_item.smag[LOW_W-1:0]);
                r_m.ph[k] <= (DW + HIW)'(i_item.dm[k]) * (DW + HIW)'(i_item.smag[MW-1:LOW_W]);
            end
            for (int j = 0; j <= QW; j++) begin
                r_d[j] <= n_d[j];
            end
            r_side <= n_side;
            r_hit  <= n_hit;
            r_at   <= n_at;
        end
    end

endmodule
